[src/nsf_pkg.sv]
// Package for the sentence framer: character codes, result bundle, hex digit decode.
// No dependencies; used by the frame engine, the result register and the top module under src.
package nsf_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 128;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;

   localparam logic [7:0] HEX_TEN = 8'd10;

   typedef struct packed {
      logic [7:0] echo_byte;
      logic [6:0] store_index;
      logic       frame_done;
      logic       frame_valid;
      logic [6:0] frame_length;
   } rsp_type;

   function automatic logic [7:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
         v = c - CHAR_UPPER_A + HEX_TEN;
      end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
         v = c - CHAR_LOWER_A + HEX_TEN;
      end else begin
         v = c - CHAR_ZERO;
      end
      return v;
   endfunction

endpackage

[src/nsf_in_stage.sv]
// Input register of the sentence framer: holds one received byte per transaction.
// Depends on nothing but the downstream ready from the result register.
module nsf_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   assign req_ready = !valid_ff || take;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

[src/nsf_frame_engine.sv]
// Frame engine: position, running XOR, checksum digits and CR tracking, plus the
// check_enable register. Uses nsf_pkg; builds one result per byte combinationally.
module nsf_frame_engine #(
   parameter int BUFFER_BYTES = nsf_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic            csr_write_data,
   input  logic            byte_valid,
   input  logic [7:0]      byte_data,
   input  logic            out_ready,
   output logic            fire,
   output nsf_pkg::rsp_type result
);

   localparam int PosW  = $clog2(BUFFER_BYTES - 2);
   localparam int LenW  = PosW + 1;
   localparam int ExtW  = (LenW > 7) ? LenW : 7;
   localparam logic [LenW-1:0] Limit = LenW'(BUFFER_BYTES - 2);

   logic            check_enable_ff;
   logic [PosW-1:0] pos_ff,   pos_in;
   logic [7:0]      xor_ff,   xor_in;
   logic            star_ff,  star_in;
   logic [1:0]      digits_ff, digits_in;
   logic [7:0]      high_ff,  high_in;
   logic [7:0]      low_ff,   low_in;
   logic            prev_cr_ff, prev_cr_in;

   logic            is_start;
   logic [PosW-1:0] idx;
   logic [LenW-1:0] len;
   logic            full;
   logic            done;
   logic            valid;
   logic [7:0]      sum;
   logic [ExtW-1:0] idx_ext;
   logic [ExtW-1:0] len_ext;
   logic [7:0]      digit;

   assign fire  = byte_valid && out_ready;
   assign digit = nsf_pkg::hex_value(byte_data);

   always_comb begin
      is_start   = (byte_data == nsf_pkg::CHAR_DOLLAR);
      pos_in     = pos_ff;
      xor_in     = xor_ff;
      star_in    = star_ff;
      digits_in  = digits_ff;
      high_in    = high_ff;
      low_in     = low_ff;
      prev_cr_in = prev_cr_ff;
      if (is_start) begin
         pos_in     = '0;
         xor_in     = '0;
         star_in    = 1'b0;
         digits_in  = '0;
         high_in    = '0;
         low_in     = '0;
         prev_cr_in = 1'b0;
      end
      idx = pos_in;

      if (idx != '0) begin
         if (!star_in) begin
            if (byte_data == nsf_pkg::CHAR_STAR) begin
               star_in = 1'b1;
            end else begin
               xor_in = xor_in ^ byte_data;
            end
         end else if (digits_in < 2'd2) begin
            if (digits_in == 2'd0) begin
               high_in = digit;
            end else begin
               low_in = digit;
            end
            digits_in = digits_in + 2'd1;
         end
      end

      len    = LenW'(idx) + LenW'(1);
      pos_in = len[PosW-1:0];
      full   = (len >= Limit);
      if (full) begin
         pos_in     = '0;
         prev_cr_in = 1'b0;
         xor_in     = '0;
         star_in    = 1'b0;
         digits_in  = '0;
         high_in    = '0;
         low_in     = '0;
         len        = '0;
      end

      sum   = {high_in[3:0], 4'b0000} + low_in;
      done  = (byte_data == nsf_pkg::CHAR_LF) && prev_cr_in;
      valid = 1'b0;
      if (done) begin
         valid = check_enable_ff ? (star_in && (sum == xor_in)) : 1'b1;
         if (!valid) begin
            pos_in     = '0;
            prev_cr_in = 1'b0;
            xor_in     = '0;
            star_in    = 1'b0;
            digits_in  = '0;
            high_in    = '0;
            low_in     = '0;
         end
      end else begin
         prev_cr_in = (byte_data == nsf_pkg::CHAR_CR);
      end

      idx_ext = ExtW'(idx);
      len_ext = done ? ExtW'(len) : '0;

      result.echo_byte    = byte_data;
      result.store_index  = idx_ext[6:0];
      result.frame_done   = done;
      result.frame_valid  = valid;
      result.frame_length = len_ext[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         check_enable_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         xor_ff     <= '0;
         star_ff    <= 1'b0;
         digits_ff  <= '0;
         high_ff    <= '0;
         low_ff     <= '0;
         prev_cr_ff <= 1'b0;
      end else if (fire) begin
         pos_ff     <= pos_in;
         xor_ff     <= xor_in;
         star_ff    <= star_in;
         digits_ff  <= digits_in;
         high_ff    <= high_in;
         low_ff     <= low_in;
         prev_cr_ff <= prev_cr_in;
      end
   end

`ifndef SYNTHESIS
   a_digits_need_star: assert property (@(posedge clock) disable iff (reset)
      (digits_ff != 2'd0) |-> star_ff)
      else $error("checksum digits taken without a star");

   a_digits_bound: assert property (@(posedge clock) disable iff (reset)
      digits_ff <= 2'd2)
      else $error("more than two checksum digits");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      LenW'(pos_ff) < Limit)
      else $error("byte position beyond buffer limit");

   a_start_pos: assert property (@(posedge clock) disable iff (reset)
      (fire && byte_data == nsf_pkg::CHAR_DOLLAR) |=> (pos_ff == PosW'(1)) && !star_ff)
      else $error("start byte did not restart the frame");

   a_bad_frame_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && done && !valid) |=> (pos_ff == '0) && !prev_cr_ff && (xor_ff == '0))
      else $error("invalid frame did not clear tracking");
`endif

endmodule

[src/nsf_out_stage.sv]
// Result register of the sentence framer: holds one result transaction until taken.
// Uses nsf_pkg::rsp_type for the payload.
module nsf_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  nsf_pkg::rsp_type load_data,
   output logic             out_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nsf_pkg::rsp_type rsp_data
);

   logic             valid_ff;
   logic             valid_in;
   nsf_pkg::rsp_type data_ff;

   assign out_ready = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[src/nmea_sentence_framer_unit.sv]
// Sentence framer for NMEA 0183 style byte streams. Each received byte passes through an
// input register, one frame-tracking step and a result register, giving one result
// transaction per byte at a sustained rate of one byte per cycle while rsp_ready is high.
// A result is held until rsp_ready takes it, and the input keeps accepting while the
// result register can drain. check_enable is written through csr_write_enable; the user
// must do this only while idle, as the block itself does not enforce it.
module nmea_sentence_framer_unit #(
   parameter int BUFFER_BYTES = nsf_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_echo_byte,
   output logic [6:0] rsp_store_index,
   output logic       rsp_frame_done,
   output logic       rsp_frame_valid,
   output logic [6:0] rsp_frame_length
);

   logic             byte_valid;
   logic [7:0]       byte_data;
   logic             out_ready;
   logic             fire;
   nsf_pkg::rsp_type result;
   nsf_pkg::rsp_type rsp_data;

   nsf_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .take        (out_ready),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   nsf_frame_engine #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_frame_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .byte_valid       (byte_valid),
      .byte_data        (byte_data),
      .out_ready        (out_ready),
      .fire             (fire),
      .result           (result)
   );

   nsf_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .load_data (result),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_echo_byte    = rsp_data.echo_byte;
   assign rsp_store_index  = rsp_data.store_index;
   assign rsp_frame_done   = rsp_data.frame_done;
   assign rsp_frame_valid  = rsp_data.frame_valid;
   assign rsp_frame_length = rsp_data.frame_length;

endmodule
